// ===== sv/rcclm_pkg.sv =====
`timescale 1ns / 1ps

package rcclm_pkg;

    localparam int CHANNELS   = 32;
    localparam int COUNT_BITS = 8;

    // channels reachable through the 32-bit masks
    localparam int LANES = (CHANNELS < 32) ? CHANNELS : 32;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << LANES) - 64'd1);

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNCLAIMED  = 2'd1,
        ST_LOWER_DOWN = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic sel;
        logic at_zero;
        logic at_max;
        logic flips;
    } lane_flags_t;

endpackage

// ===== sv/refcounted_channel_level_mask.sv =====
`timescale 1ns / 1ps

// Reference-counted channel level mask. Each input transaction raises
// (s_tuser = 1) or lowers (s_tuser = 0) the channels set in s_tdata; every
// channel keeps a raise count and its level goes high on the 0-to-1 step and
// low on the 1-to-0 step. Each transaction yields one result: new level mask,
// changed mask and status (0 applied, 1 unclaimed channel, 2 lower while
// down, 3 count overflow); a rejected transaction changes nothing. Requests
// outside claimed_mask are rejected. The user must keep claimed_mask written
// through cfg_wr_en/cfg_wr_data while idle; the block does not enforce it.
// One transaction per cycle unless m_tready stalls the output: all counters
// are checked and updated in parallel on acceptance and the result registered.
module refcounted_channel_level_mask
    import rcclm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,  // claimed_mask
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // [31:0] channel_mask
    input  logic        s_tuser,      // [0] level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [31:0] output_mask, [63:32] changed_mask
    output logic [1:0]  m_tuser       // [1:0] status
);

    logic [31:0]             claimed_reg;
    logic [31:0]             level_reg;
    logic [31:0]             level_next;
    logic                    m_valid_reg;
    logic [63:0]             m_data_reg;
    status_t                 m_status_reg;
    logic                    accept;
    logic                    commit;
    logic [31:0]             changed;
    status_t                 status;
    lane_flags_t [LANES-1:0] flags;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rcclm_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (s_tdata[g]),
            .raise   (s_tuser),
            .commit  (commit),
            .flags   (flags[g])
        );
    end

    rcclm_merge u_merge (
        .accept  (accept),
        .raise   (s_tuser),
        .req     (s_tdata),
        .claimed (claimed_reg),
        .flags   (flags),
        .commit  (commit),
        .changed (changed),
        .status  (status)
    );

    assign level_next = s_tuser ? (level_reg | changed) : (level_reg & ~changed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            claimed_reg <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                claimed_reg <= cfg_wr_data;
            end
            if (commit) begin
                level_reg <= level_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg   <= {changed, level_next};
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== sv/rcclm_lane.sv =====
`timescale 1ns / 1ps

module rcclm_lane
    import rcclm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        req,
    input  logic        raise,
    input  logic        commit,
    output lane_flags_t flags
);

    count_t count_reg;
    count_t count_next;

    always_comb begin
        flags.sel     = req;
        flags.at_zero = (count_reg == '0);
        flags.at_max  = (&count_reg);
        flags.flips   = raise ? (count_reg == '0) : (count_reg == COUNT_BITS'(1));
        count_next    = raise ? count_reg + COUNT_BITS'(1) : count_reg - COUNT_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (commit && req) begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/rcclm_merge.sv =====
`timescale 1ns / 1ps

module rcclm_merge
    import rcclm_pkg::*;
(
    input  logic                    accept,
    input  logic                    raise,
    input  logic [31:0]             req,
    input  logic [31:0]             claimed,
    input  lane_flags_t [LANES-1:0] flags,
    output logic                    commit,
    output logic [31:0]             changed,
    output status_t                 status
);

    logic [LANES-1:0] hit_zero;
    logic [LANES-1:0] hit_max;
    logic [LANES-1:0] flip;
    logic             unclaimed;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            hit_zero[i] = flags[i].sel & flags[i].at_zero;
            hit_max[i]  = flags[i].sel & flags[i].at_max;
            flip[i]     = flags[i].sel & flags[i].flips;
        end
        unclaimed = |(req & ~(claimed & ADDR_MASK));
        if (unclaimed) begin
            status = ST_UNCLAIMED;
        end else if (!raise && (|hit_zero)) begin
            status = ST_LOWER_DOWN;
        end else if (raise && (|hit_max)) begin
            status = ST_OVERFLOW;
        end else begin
            status = ST_OK;
        end
        commit  = accept && (status == ST_OK);
        changed = (status == ST_OK) ? 32'(flip) : '0;
    end

endmodule
